FILE: rtl/baro_pkg.sv
// Shared types and constants for the barometric sensor compensation block.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
package baro_pkg;

    localparam int RAW_W     = 24;
    localparam int COEF_W    = 16;
    localparam int TEMP_W    = 19;
    localparam int PRES_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 3;

    // Temperature thresholds in hundredths of a degree and the pressure limit in Pa.
    localparam int TEMP_REF    = 2000;
    localparam int FROST_TEMP  = -1500;
    localparam int FROST_OFS   = 1500;
    localparam int PRES_LIMIT  = 120000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENS_T1,
        CFG_OFF_T1,
        CFG_SENS_TCS,
        CFG_OFF_TCO,
        CFG_REF_TEMP,
        CFG_TEMP_SENS
    } cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK,
        STATUS_ZERO,
        STATUS_RANGE
    } status_t;

    typedef struct packed {
        logic [COEF_W-1:0] sens_t1;
        logic [COEF_W-1:0] off_t1;
        logic [COEF_W-1:0] sens_tcs;
        logic [COEF_W-1:0] off_tco;
        logic [COEF_W-1:0] ref_temp;
        logic [COEF_W-1:0] temp_sens;
    } coef_t;

    localparam coef_t COEF_RESET = '{
        sens_t1:   16'd40127,
        off_t1:    16'd36924,
        sens_tcs:  16'd23317,
        off_tco:   16'd23282,
        ref_temp:  16'd33464,
        temp_sens: 16'd28312
    };

endpackage

FILE: rtl/baro_sample_if.sv
// Input channel carrying one pair of raw conversion results per word.
// Depends on baro_pkg for field widths.
interface baro_sample_if;
    logic                         valid;
    logic                         ready;
    logic [baro_pkg::RAW_W-1:0]   raw_pressure;
    logic [baro_pkg::RAW_W-1:0]   raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

FILE: rtl/baro_result_if.sv
// Output channel carrying one compensated temperature and pressure per word.
// Depends on baro_pkg for field widths.
interface baro_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [baro_pkg::TEMP_W-1:0] temp_centi;
    logic signed [baro_pkg::PRES_W-1:0] pressure_pa;
    logic [baro_pkg::STATUS_W-1:0]      status;

    modport source (output valid, output temp_centi, output pressure_pa, output status,
                    input ready);
    modport sink   (input valid, input temp_centi, input pressure_pa, input status,
                    output ready);
endinterface

FILE: rtl/baro_cfg_if.sv
// Configuration write channel: register index and write data per word.
// Depends on baro_pkg for field widths.
interface baro_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [baro_pkg::CFG_IDX_W-1:0]   index;
    logic [baro_pkg::COEF_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/baro_sensor_compensation.sv
// Top level of the barometric sensor compensation block.
// Depends on baro_pkg, the three channel interfaces, baro_cfg_regs and baro_pipe.
//
// Usage:
//   The sample channel takes one word holding a raw 24-bit pressure reading and
//   a raw 24-bit temperature reading. The result channel returns one word per
//   sample: temperature in hundredths of a degree Celsius, pressure in pascals
//   and a status code (ok, a raw reading was zero, or pressure out of range).
//   Words move at a rising edge where valid and ready are both high.
//   The cfg channel writes the six calibration coefficients by index; it is
//   always ready, and an index past the last coefficient is ignored. Write the
//   coefficients only while no sample is in flight.
//
//   A sample passes through the eleven stage registers in order before its
//   result word becomes valid. Throughput is one word per cycle while the
//   receiver holds ready high; the widest step is the 24 by 40 bit pressure
//   product, split into two partial products and summed in the following
//   stage.
//
//   Reset empties the pipeline and loads the factory coefficients. When the
//   receiver holds ready low, the result word stays put, and upstream stages
//   keep filling any empty slots, so sample.ready drops only once every stage
//   holds a word. Nothing is lost or repeated across a stall.
module baro_sensor_compensation
(
    input  logic            clk,
    input  logic            rst_n,
    baro_sample_if.sink     sample,
    baro_result_if.source   result,
    baro_cfg_if.sink        cfg
);

    // Current calibration coefficients, shared by the first three stages.
    baro_pkg::coef_t coef;

    baro_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .coef  (coef)
    );

    baro_pipe u_pipe
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .result (result),
        .coef   (coef)
    );

endmodule

FILE: rtl/baro_cfg_regs.sv
// Calibration coefficient register file written through the configuration channel.
// Depends on baro_pkg and baro_cfg_if.
module baro_cfg_regs
(
    input  logic               clk,
    input  logic               rst_n,
    baro_cfg_if.sink           cfg,
    output baro_pkg::coef_t    coef
);

    baro_pkg::coef_t coef_reg;
    baro_pkg::coef_t coef_next;

    assign cfg.ready = 1'b1;
    assign coef      = coef_reg;

    // Writes to an index past the last coefficient are dropped.
    always_comb
    begin
        coef_next = coef_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                baro_pkg::CFG_SENS_T1:   coef_next.sens_t1   = cfg.data;
                baro_pkg::CFG_OFF_T1:    coef_next.off_t1    = cfg.data;
                baro_pkg::CFG_SENS_TCS:  coef_next.sens_tcs  = cfg.data;
                baro_pkg::CFG_OFF_TCO:   coef_next.off_tco   = cfg.data;
                baro_pkg::CFG_REF_TEMP:  coef_next.ref_temp  = cfg.data;
                baro_pkg::CFG_TEMP_SENS: coef_next.temp_sens = cfg.data;
                default:                 coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= baro_pkg::COEF_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

endmodule

FILE: rtl/baro_pipe.sv
// Eleven-stage compensation datapath with per-stage valid bits and bubble-collapsing stall.
// Depends on baro_pkg, baro_sample_if and baro_result_if.
module baro_pipe
(
    input  logic               clk,
    input  logic               rst_n,
    baro_sample_if.sink        sample,
    baro_result_if.source      result,
    input  baro_pkg::coef_t    coef
);

    localparam int STAGES = 11;

    localparam logic signed [19:0] TEMP_REF_W  = 20'(baro_pkg::TEMP_REF);
    localparam logic signed [19:0] FROST_W     = 20'(baro_pkg::FROST_TEMP);
    localparam logic signed [19:0] FROST_OFS_W = 20'(baro_pkg::FROST_OFS);
    localparam logic signed [31:0] PRES_LIM_W  = 32'(baro_pkg::PRES_LIMIT);

    // Handshake control.
    logic [STAGES:1] vld_reg;
    logic [STAGES:1] en;

    // Values carried unchanged along the pipeline.
    logic [23:0]        d1_reg   [1:7];
    logic [10:1]        zero_reg;
    logic signed [19:0] temp_reg [4:10];
    logic [41:0]        off_reg  [3:6];
    logic [39:0]        sens_reg [3:6];
    logic [41:0]        offf_reg [7:9];
    logic [4:3]         cold_reg;
    logic [4:3]         frost_reg;

    // Stage 1: temperature difference.
    logic signed [24:0] dt_s1_next, dt_s1_reg;
    logic               zero_s1_next;
    // Stage 2: coefficient products and the square of the temperature difference.
    logic signed [41:0] p6_s2_next, p6_s2_reg;
    logic signed [41:0] p4_s2_next, p4_s2_reg;
    logic signed [41:0] p3_s2_next, p3_s2_reg;
    logic signed [49:0] pdd_s2_next, pdd_s2_reg;
    // Stage 3: first-order temperature, offset and sensitivity.
    logic signed [18:0] a_s3_next, a_s3_reg;
    logic signed [19:0] b_s3_next, b_s3_reg;
    logic signed [19:0] temp_s3_next, temp_s3_reg;
    logic [18:0]        t2_s3_next, t2_s3_reg;
    logic               cold_s3_next, frost_s3_next;
    logic [41:0]        off_s3_next;
    logic [39:0]        sens_s3_next;
    // Stage 4: squares and corrected temperature.
    logic [37:0]        aa_s4_next, aa_s4_reg;
    logic [39:0]        bb_s4_next, bb_s4_reg;
    logic signed [19:0] temp_s4_next;
    // Stage 5: constant multiples of the squares.
    logic [42:0]        fa_s5_next, fa_s5_reg;
    logic [42:0]        sb_s5_next, sb_s5_reg;
    logic [42:0]        eb_s5_next, eb_s5_reg;
    // Stage 6: second-order offset and sensitivity terms.
    logic [42:0]        off2_s6_next, off2_s6_reg;
    logic [42:0]        sens2_s6_next, sens2_s6_reg;
    // Stage 7: corrected offset and sensitivity.
    logic [41:0]        offf_s7_next;
    logic [39:0]        sensf_s7_next, sensf_s7_reg;
    // Stage 8: partial products of the pressure multiply.
    logic signed [44:0] pph_s8_next, pph_s8_reg;
    logic [43:0]        ppl_s8_next, ppl_s8_reg;
    // Stage 9: full product.
    logic [64:0]        prod_s9_next, prod_s9_reg;
    // Stage 10: pressure.
    logic [46:0]        q_s10;
    logic [31:0]        p_s10_next, p_s10_reg;
    // Stage 11: output word.
    logic signed [18:0] temp_out_next, temp_out_reg;
    logic signed [31:0] pres_out_next, pres_out_reg;
    logic [1:0]         status_next, status_reg;

    // A stage loads when it is empty or when the stage after it loads too.
    always_comb
    begin
        en[STAGES] = !vld_reg[STAGES] || result.ready;
        for (int k = STAGES - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k + 1];
        end
    end

    assign sample.ready       = en[1];
    assign result.valid       = vld_reg[STAGES];
    assign result.temp_centi  = temp_out_reg;
    assign result.pressure_pa = pres_out_reg;
    assign result.status      = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                vld_reg[1] <= sample.valid;
            end
            for (int k = 2; k <= STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k - 1];
                end
            end
        end
    end

    always_comb
    begin
        // Stage 1
        dt_s1_next   = $signed({1'b0, sample.raw_temperature})
                     - $signed({1'b0, coef.ref_temp, 8'h00});
        zero_s1_next = (sample.raw_pressure == '0) || (sample.raw_temperature == '0);

        // Stage 2
        p6_s2_next  = dt_s1_reg * $signed({1'b0, coef.temp_sens});
        p4_s2_next  = dt_s1_reg * $signed({1'b0, coef.off_tco});
        p3_s2_next  = dt_s1_reg * $signed({1'b0, coef.sens_tcs});
        pdd_s2_next = dt_s1_reg * dt_s1_reg;

        // Stage 3: a is the signed difference of the temperature from the reference.
        a_s3_next     = p6_s2_reg[41:23];
        temp_s3_next  = $signed({p6_s2_reg[41], p6_s2_reg[41:23]}) + TEMP_REF_W;
        cold_s3_next  = p6_s2_reg[41];
        frost_s3_next = temp_s3_next < FROST_W;
        b_s3_next     = temp_s3_next + FROST_OFS_W;
        off_s3_next   = {10'b0, coef.off_t1, 16'h0000}
                      + {{7{p4_s2_reg[41]}}, p4_s2_reg[41:7]};
        sens_s3_next  = {9'b0, coef.sens_t1, 15'h0000}
                      + {{6{p3_s2_reg[41]}}, p3_s2_reg[41:8]};
        t2_s3_next    = cold_s3_next ? pdd_s2_reg[49:31] : '0;

        // Stage 4: the operands are sign-extended to the full square width first.
        aa_s4_next   = cold_reg[3] ? 38'(a_s3_reg) * 38'(a_s3_reg) : '0;
        bb_s4_next   = frost_reg[3] ? 40'(b_s3_reg) * 40'(b_s3_reg) : '0;
        temp_s4_next = temp_s3_reg - $signed({1'b0, t2_s3_reg});

        // Stage 5: 5*a^2, 7*b^2 and 11*b^2 as shift-and-add.
        fa_s5_next = {3'b0, aa_s4_reg, 2'b00} + {5'b0, aa_s4_reg};
        sb_s5_next = {bb_s4_reg, 3'b000} - {3'b0, bb_s4_reg};
        eb_s5_next = {bb_s4_reg, 3'b000} + {2'b0, bb_s4_reg, 1'b0} + {3'b0, bb_s4_reg};

        // Stage 6: the terms are never negative, so the shifts are logical.
        off2_s6_next  = (fa_s5_reg >> 1) + sb_s5_reg;
        sens2_s6_next = (fa_s5_reg >> 2) + (eb_s5_reg >> 1);

        // Stage 7
        offf_s7_next  = off_reg[6] - off2_s6_reg[41:0];
        sensf_s7_next = sens_reg[6] - sens2_s6_reg[39:0];

        // Stage 8: split the sensitivity into a signed high and an unsigned low half.
        pph_s8_next = $signed({1'b0, d1_reg[7]}) * $signed(sensf_s7_reg[39:20]);
        ppl_s8_next = d1_reg[7] * sensf_s7_reg[19:0];

        // Stage 9
        prod_s9_next = {pph_s8_reg, 20'h00000} + {21'b0, ppl_s8_reg};

        // Stage 10: the pressure is the difference shifted right by 15, bits 46:15 of it.
        q_s10      = {{3{prod_s9_reg[64]}}, prod_s9_reg[64:21]}
                   - {{5{offf_reg[9][41]}}, offf_reg[9]};
        p_s10_next = q_s10[46:15];

        // Stage 11
        if (zero_reg[10])
        begin
            temp_out_next = '0;
            pres_out_next = '0;
            status_next   = baro_pkg::STATUS_ZERO;
        end
        else
        begin
            temp_out_next = temp_reg[10][18:0];
            pres_out_next = $signed(p_s10_reg);
            if (($signed(p_s10_reg) > 32'sd0) && ($signed(p_s10_reg) < PRES_LIM_W))
            begin
                status_next = baro_pkg::STATUS_OK;
            end
            else
            begin
                status_next = baro_pkg::STATUS_RANGE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            dt_s1_reg   <= dt_s1_next;
            zero_reg[1] <= zero_s1_next;
            d1_reg[1]   <= sample.raw_pressure;
        end
        for (int k = 2; k <= 7; k++)
        begin
            if (en[k])
            begin
                d1_reg[k] <= d1_reg[k - 1];
            end
        end
        for (int k = 2; k <= 10; k++)
        begin
            if (en[k])
            begin
                zero_reg[k] <= zero_reg[k - 1];
            end
        end
        if (en[2])
        begin
            p6_s2_reg  <= p6_s2_next;
            p4_s2_reg  <= p4_s2_next;
            p3_s2_reg  <= p3_s2_next;
            pdd_s2_reg <= pdd_s2_next;
        end
        if (en[3])
        begin
            a_s3_reg     <= a_s3_next;
            b_s3_reg     <= b_s3_next;
            temp_s3_reg  <= temp_s3_next;
            t2_s3_reg    <= t2_s3_next;
            cold_reg[3]  <= cold_s3_next;
            frost_reg[3] <= frost_s3_next;
            off_reg[3]   <= off_s3_next;
            sens_reg[3]  <= sens_s3_next;
        end
        if (en[4])
        begin
            aa_s4_reg    <= aa_s4_next;
            bb_s4_reg    <= bb_s4_next;
            temp_reg[4]  <= temp_s4_next;
            cold_reg[4]  <= cold_reg[3];
            frost_reg[4] <= frost_reg[3];
        end
        for (int k = 4; k <= 6; k++)
        begin
            if (en[k])
            begin
                off_reg[k]  <= off_reg[k - 1];
                sens_reg[k] <= sens_reg[k - 1];
            end
        end
        for (int k = 5; k <= 10; k++)
        begin
            if (en[k])
            begin
                temp_reg[k] <= temp_reg[k - 1];
            end
        end
        if (en[5])
        begin
            fa_s5_reg <= cold_reg[4] ? fa_s5_next : '0;
            sb_s5_reg <= frost_reg[4] ? sb_s5_next : '0;
            eb_s5_reg <= frost_reg[4] ? eb_s5_next : '0;
        end
        if (en[6])
        begin
            off2_s6_reg  <= off2_s6_next;
            sens2_s6_reg <= sens2_s6_next;
        end
        if (en[7])
        begin
            offf_reg[7]  <= offf_s7_next;
            sensf_s7_reg <= sensf_s7_next;
        end
        for (int k = 8; k <= 9; k++)
        begin
            if (en[k])
            begin
                offf_reg[k] <= offf_reg[k - 1];
            end
        end
        if (en[8])
        begin
            pph_s8_reg <= pph_s8_next;
            ppl_s8_reg <= ppl_s8_next;
        end
        if (en[9])
        begin
            prod_s9_reg <= prod_s9_next;
        end
        if (en[10])
        begin
            p_s10_reg <= p_s10_next;
        end
        if (en[11])
        begin
            temp_out_reg <= temp_out_next;
            pres_out_reg <= pres_out_next;
            status_reg   <= status_next;
        end
    end

endmodule
